// ===== sv/complex_matrix_multiply_accumulate_core_macros.svh =====
// Assertion macros shared by the checker of the complex matrix MAC core.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef COMPLEX_MATRIX_MULTIPLY_ACCUMULATE_CORE_MACROS_SVH
`define COMPLEX_MATRIX_MULTIPLY_ACCUMULATE_CORE_MACROS_SVH

// Same-cycle implication.
`define CMMA_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CMMA_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cmma_pkg.sv =====
// Types, constants and helpers of the complex matrix MAC core.
// No dependencies.
package cmma_pkg;

  localparam int DIM    = 4;
  localparam int CELLS  = DIM * DIM;
  localparam int IDX_W  = 3;
  localparam int CNT_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DATA_W = 64;
  // 2*DIM products of up to 2^62 per part plus the preloaded C term.
  localparam int ACC_W  = 64 + $clog2(2 * DIM) + 1;
  localparam logic [IDX_W:0] DIM_LIM = (IDX_W + 1)'(DIM);

  // func codes
  localparam logic [2:0] FN_LOAD_A = 3'd0;
  localparam logic [2:0] FN_LOAD_B = 3'd1;
  localparam logic [2:0] FN_LOAD_C = 3'd2;
  localparam logic [2:0] FN_MUL    = 3'd3;
  localparam logic [2:0] FN_ADD    = 3'd4;
  localparam logic [2:0] FN_SUB    = 3'd5;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic signed [31:0] re_part;
    logic signed [31:0] im_part;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    logic              saturated;
    logic              last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_part_t;

  function automatic addr_t cell_addr(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
    return ADDR_W'(int'(r) * DIM + int'(c));
  endfunction

  // Floor shift by 16 and clip to 32 bits.
  function automatic sat_part_t sat_q16(input logic signed [ACC_W-1:0] acc);
    sat_part_t res;
    logic      fits;
    fits = (&acc[ACC_W-1:47]) || !(|acc[ACC_W-1:47]);
    res.sat = !fits;
    if (fits) res.val = acc[47:16];
    else if (acc[ACC_W-1]) res.val = 32'h8000_0000;
    else res.val = 32'h7FFF_FFFF;
    return res;
  endfunction

endpackage

// ===== sv/complex_matrix_multiply_accumulate_core.sv =====
// Complex matrix multiply-accumulate core, top level.
// Uses cmma_pkg and three cmma_ram instances for the A, B and C matrices.
//
// Usage:
//  - One command channel: a word is taken on a rising edge with start high
//    and busy low. func selects load A/B/C (one element at row,col), or a
//    compute: A*B, C + A*B or C - A*B. Loads with row or col >= DIM and
//    func codes 6/7 are dropped.
//  - A load does not raise busy, so loads can stream back to back.
//  - A compute raises busy and walks the result row-major. For each element,
//    every k step runs its complex multiply-accumulate through the single
//    shared 32x32 multiplier one partial product at a time, followed by a
//    drain and a format state.
//  - Results come out on out_word with out_valid high for exactly one cycle.
//    The receiver cannot stall; every word must be taken when strobed.
//    busy drops in the cycle the last word (last = 1) is strobed.
//  - Reset (rst_n low, synchronous) idles the sequencer and clears the
//    accumulators; matrix memories keep contents and are undefined until
//    loaded. Stored matrices persist across commands for reuse.
module complex_matrix_multiply_accumulate_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cmma_pkg::in_word_t  in_word,
  output logic                out_valid,
  output cmma_pkg::out_word_t out_word
);

  localparam cmma_pkg::cnt_t LAST_IDX = cmma_pkg::CNT_W'(cmma_pkg::DIM - 1);

  cmma_pkg::state_t state_r, state_nxt;

  cmma_pkg::cnt_t i_r, j_r, k_r;
  logic [1:0]     p_r;              // multiply phase within one k step
  logic           use_c_r, neg_r;

  logic                          prod_v_r, prod_sub_r, prod_im_r;
  logic signed [63:0]            prod_r;
  logic signed [cmma_pkg::ACC_W-1:0] acc_re_r, acc_im_r;

  cmma_pkg::out_word_t out_word_r;
  logic                out_valid_r;

  // command decode
  logic in_acc, is_load, is_comp, in_range;
  assign in_acc   = start && (state_r == cmma_pkg::ST_IDLE);
  assign is_load  = (in_word.func == cmma_pkg::FN_LOAD_A) ||
                    (in_word.func == cmma_pkg::FN_LOAD_B) ||
                    (in_word.func == cmma_pkg::FN_LOAD_C);
  assign is_comp  = (in_word.func == cmma_pkg::FN_MUL) ||
                    (in_word.func == cmma_pkg::FN_ADD) ||
                    (in_word.func == cmma_pkg::FN_SUB);
  assign in_range = ({1'b0, in_word.row} < cmma_pkg::DIM_LIM) &&
                    ({1'b0, in_word.col} < cmma_pkg::DIM_LIM);

  logic wr_ok;
  assign wr_ok = in_acc && is_load && in_range;

  cmma_pkg::addr_t      waddr;
  logic [63:0]          wdata;
  assign waddr = cmma_pkg::cell_addr(in_word.row, in_word.col);
  assign wdata = {in_word.im_part, in_word.re_part};

  // element walk
  logic           elem_last;
  cmma_pkg::cnt_t ni, nj;
  assign elem_last = (i_r == LAST_IDX) && (j_r == LAST_IDX);
  always_comb begin
    if (j_r == LAST_IDX) begin
      nj = '0;
      ni = i_r + 1'b1;
    end else begin
      nj = j_r + 1'b1;
      ni = i_r;
    end
  end

  // sequencer
  logic           rd_en, mul_en;
  cmma_pkg::cnt_t rd_i, rd_j, rd_k;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cmma_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    mul_en    = 1'b0;
    rd_i      = i_r;
    rd_j      = j_r;
    rd_k      = '0;
    unique case (state_r)
      cmma_pkg::ST_IDLE: begin
        if (in_acc && is_comp) state_nxt = cmma_pkg::ST_INIT;
      end
      cmma_pkg::ST_INIT: begin
        rd_en     = 1'b1;
        state_nxt = cmma_pkg::ST_MAC;
      end
      cmma_pkg::ST_MAC: begin
        mul_en = 1'b1;
        if (p_r == 2'd3) begin
          if (k_r == LAST_IDX) begin
            state_nxt = cmma_pkg::ST_DRAIN;
          end else begin
            rd_en = 1'b1;
            rd_k  = k_r + 1'b1;
          end
        end
      end
      cmma_pkg::ST_DRAIN: begin
        state_nxt = cmma_pkg::ST_OUT;
      end
      cmma_pkg::ST_OUT: begin
        if (elem_last) begin
          state_nxt = cmma_pkg::ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_i      = ni;
          rd_j      = nj;
          state_nxt = cmma_pkg::ST_MAC;
        end
      end
      default: state_nxt = cmma_pkg::ST_IDLE;
    endcase
  end

  // matrix stores, words packed {im, re}
  logic [63:0] a_q, b_q, c_q;

  cmma_ram #(.Depth(cmma_pkg::CELLS), .AddrW(cmma_pkg::ADDR_W), .DataW(cmma_pkg::DATA_W))
  u_a_ram (
    .clk   (clk),
    .we    (wr_ok && (in_word.func == cmma_pkg::FN_LOAD_A)),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (cmma_pkg::cell_addr(cmma_pkg::IDX_W'(rd_i), cmma_pkg::IDX_W'(rd_k))),
    .rdata (a_q)
  );

  cmma_ram #(.Depth(cmma_pkg::CELLS), .AddrW(cmma_pkg::ADDR_W), .DataW(cmma_pkg::DATA_W))
  u_b_ram (
    .clk   (clk),
    .we    (wr_ok && (in_word.func == cmma_pkg::FN_LOAD_B)),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (cmma_pkg::cell_addr(cmma_pkg::IDX_W'(rd_k), cmma_pkg::IDX_W'(rd_j))),
    .rdata (b_q)
  );

  cmma_ram #(.Depth(cmma_pkg::CELLS), .AddrW(cmma_pkg::ADDR_W), .DataW(cmma_pkg::DATA_W))
  u_c_ram (
    .clk   (clk),
    .we    (wr_ok && (in_word.func == cmma_pkg::FN_LOAD_C)),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (cmma_pkg::cell_addr(cmma_pkg::IDX_W'(rd_i), cmma_pkg::IDX_W'(rd_j))),
    .rdata (c_q)
  );

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      p_r     <= '0;
      use_c_r <= 1'b0;
      neg_r   <= 1'b0;
    end else begin
      unique case (state_r)
        cmma_pkg::ST_IDLE: begin
          if (in_acc && is_comp) begin
            i_r     <= '0;
            j_r     <= '0;
            k_r     <= '0;
            p_r     <= '0;
            use_c_r <= (in_word.func != cmma_pkg::FN_MUL);
            neg_r   <= (in_word.func == cmma_pkg::FN_SUB);
          end
        end
        cmma_pkg::ST_MAC: begin
          p_r <= p_r + 2'd1;
          if (p_r == 2'd3) k_r <= (k_r == LAST_IDX) ? '0 : k_r + 1'b1;
        end
        cmma_pkg::ST_OUT: begin
          if (!elem_last) begin
            i_r <= ni;
            j_r <= nj;
          end
        end
        default: ;
      endcase
    end
  end

  // shared multiplier: phase 0 ar*br, 1 ai*bi, 2 ai*br, 3 ar*bi
  logic signed [31:0] ar, ai, br, bi, op_x, op_y;
  assign ar   = a_q[31:0];
  assign ai   = a_q[63:32];
  assign br   = b_q[31:0];
  assign bi   = b_q[63:32];
  assign op_x = (p_r == 2'd0 || p_r == 2'd3) ? ar : ai;
  assign op_y = (p_r == 2'd0 || p_r == 2'd2) ? br : bi;

  always_ff @(posedge clk) begin
    if (!rst_n) prod_v_r <= 1'b0;
    else prod_v_r <= mul_en;
  end

  always_ff @(posedge clk) begin
    prod_r     <= op_x * op_y;
    prod_sub_r <= (p_r == 2'd1) ? !neg_r : neg_r;  // ai*bi enters the real part negated
    prod_im_r  <= p_r[1];
  end

  // accumulate
  logic signed [cmma_pkg::ACC_W-1:0] addend, c_init_re, c_init_im;
  logic                              acc_first;
  assign addend    = {{(cmma_pkg::ACC_W-64){prod_r[63]}}, prod_r};
  assign c_init_re = {{(cmma_pkg::ACC_W-48){c_q[31]}}, c_q[31:0], 16'h0000};
  assign c_init_im = {{(cmma_pkg::ACC_W-48){c_q[63]}}, c_q[63:32], 16'h0000};
  assign acc_first = (state_r == cmma_pkg::ST_MAC) && (k_r == '0) && (p_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (acc_first) begin
      acc_re_r <= use_c_r ? c_init_re : '0;
      acc_im_r <= use_c_r ? c_init_im : '0;
    end else if (prod_v_r) begin
      if (prod_im_r) acc_im_r <= prod_sub_r ? acc_im_r - addend : acc_im_r + addend;
      else acc_re_r <= prod_sub_r ? acc_re_r - addend : acc_re_r + addend;
    end
  end

  // result formatting
  cmma_pkg::sat_part_t sat_re, sat_im;
  assign sat_re = cmma_pkg::sat_q16(acc_re_r);
  assign sat_im = cmma_pkg::sat_q16(acc_im_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= (state_r == cmma_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (state_r == cmma_pkg::ST_OUT) begin
      out_word_r.out_row   <= cmma_pkg::IDX_W'(i_r);
      out_word_r.out_col   <= cmma_pkg::IDX_W'(j_r);
      out_word_r.out_re    <= sat_re.val;
      out_word_r.out_im    <= sat_im.val;
      out_word_r.saturated <= sat_re.sat || sat_im.sat;
      out_word_r.last      <= elem_last;
    end
  end

  assign busy      = (state_r != cmma_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/cmma_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cmma_ram #(
  parameter int Depth = 16,
  parameter int AddrW = 4,
  parameter int DataW = 64
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [DataW-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [DataW-1:0] rdata
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== sv/cmma_checker.sv =====
// Port-level checker for the complex matrix MAC core, bound to the top level.
// Depends on cmma_pkg and complex_matrix_multiply_accumulate_core_macros.svh.
`include "complex_matrix_multiply_accumulate_core_macros.svh"

module cmma_port_props (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input cmma_pkg::in_word_t  in_word,
  input logic                out_valid,
  input cmma_pkg::out_word_t out_word
);

  logic take, take_comp;
  assign take      = start && !busy;
  assign take_comp = take && ((in_word.func == cmma_pkg::FN_MUL) ||
                              (in_word.func == cmma_pkg::FN_ADD) ||
                              (in_word.func == cmma_pkg::FN_SUB));

  `CMMA_AST_NXT(a_comp_busy, take_comp, busy, "compute word did not raise busy")
  `CMMA_AST_NXT(a_load_quiet, take && !take_comp, !busy && !out_valid, "load word left block busy")
  `CMMA_AST_NXT(a_strobe_gap, out_valid, !out_valid, "result words back to back")
  `CMMA_AST_IMP(a_mid_busy, out_valid && !out_word.last, busy, "busy dropped before last word")
  `CMMA_AST_IMP(a_last_pos, out_valid && out_word.last,
                (out_word.out_row == cmma_pkg::IDX_W'(cmma_pkg::DIM - 1)) &&
                (out_word.out_col == cmma_pkg::IDX_W'(cmma_pkg::DIM - 1)),
                "last flag on wrong element")

endmodule

bind complex_matrix_multiply_accumulate_core cmma_port_props u_cmma_checker (.*);
